@@ src/tbe_pkg.sv @@
package tbe_pkg;

	localparam int PW       = 32;          // Q16.16 coordinate
	localparam int EW       = PW + 1;      // edge / point difference
	localparam int BW       = 68;          // wide multiplier operand (adjugate)
	localparam int CH       = 17;          // multiplier chunk of the wide operand
	localparam int NCH      = BW / CH;
	localparam int ACC_W    = 104;         // accumulator, holds the determinant
	localparam int INV_W    = 48;          // Q16.32 inverse entry
	localparam int FRAC_SH  = 24;          // 2^-48 to Q8.24
	localparam int RC_W     = ACC_W - FRAC_SH;
	localparam int BS_W     = RC_W + 2;
	localparam int AXES     = 3;
	localparam int CORNER_WORDS = 12;
	localparam int INV_WORDS    = 9;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'h80_0000);
	localparam logic signed [PW-1:0]    ONE_Q24  = 32'sh0100_0000;
	localparam logic signed [BS_W-1:0]  S_MAX    = BS_W'(32'sh7fff_ffff);
	localparam logic signed [BS_W-1:0]  S_MIN    = BS_W'(32'sh8000_0000);

	typedef enum logic [3:0] {
		ST_IDLE, ST_WR, ST_LRD, ST_EDGE, ST_ADJ, ST_DET, ST_CHK, ST_INV,
		ST_QRD, ST_QDIFF, ST_QMAC, ST_QFIN, ST_DONE
	} st_t;

	typedef struct packed {
		logic start;
		logic clear;
		logic sub;
	} mac_cmd_t;

	function automatic logic [1:0] inc3(input logic [1:0] v);
		return (v == 2'd2) ? 2'd0 : v + 2'd1;
	endfunction

	function automatic logic [3:0] idx9(input logic [1:0] r, input logic [1:0] c);
		return {2'b00, r} * 4'd3 + {2'b00, c};
	endfunction

	function automatic logic signed [PW-1:0] sat32(input logic signed [BS_W-1:0] v);
		logic signed [PW-1:0] r;
		if (v > S_MAX) r = S_MAX[PW-1:0];
		else if (v < S_MIN) r = S_MIN[PW-1:0];
		else r = v[PW-1:0];
		return r;
	endfunction

endpackage

@@ src/tbe_if.sv @@
interface tbe_req_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic [3:0]         tet_index;
	logic [1:0]         corner_slot;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;

	modport source(output valid, op, tet_index, corner_slot, pos_x, pos_y, pos_z,
		input ready);
	modport sink(input valid, op, tet_index, corner_slot, pos_x, pos_y, pos_z,
		output ready);
endinterface

interface tbe_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] bary_0;
	logic signed [31:0] bary_1;
	logic signed [31:0] bary_2;
	logic signed [31:0] bary_3;
	logic               inside_res;
	logic               degenerate;

	modport source(output valid, bary_0, bary_1, bary_2, bary_3, inside_res, degenerate,
		input ready);
	modport sink(input valid, bary_0, bary_1, bary_2, bary_3, inside_res, degenerate,
		output ready);
endinterface

@@ src/tbe_ram.sv @@
module tbe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/tbe_mac.sv @@
module tbe_mac (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tbe_pkg::mac_cmd_t               cmd,
	input  logic signed [tbe_pkg::EW-1:0]   a,
	input  logic signed [tbe_pkg::BW-1:0]   b,
	input  logic signed [tbe_pkg::ACC_W-1:0] init,
	output logic                            done,
	output logic signed [tbe_pkg::ACC_W-1:0] acc
);
	import tbe_pkg::*;

	localparam int PRW = EW + BW;

	logic             busy_q, done_q, neg_q, clr_q;
	logic [2:0]       cnt_q;
	logic [EW-1:0]    am_q;
	logic [BW-1:0]    bm_q;
	logic [PRW-1:0]   prod_q;
	logic signed [ACC_W-1:0] acc_q, base, sp;
	logic [EW-1:0]    a_mag;
	logic [BW-1:0]    b_mag;
	logic [EW+CH-1:0] part;

	assign a_mag = a[EW-1] ? (~a + 1'b1) : a;
	assign b_mag = b[BW-1] ? (~b + 1'b1) : b;
	assign part  = am_q * bm_q[BW-1 -: CH];
	assign base  = clr_q ? init : acc_q;
	assign sp    = signed'(ACC_W'(prod_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 3'(NCH)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	// top chunk first: shift the partial sum up and add the next partial product
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			am_q   <= a_mag;
			bm_q   <= b_mag;
			neg_q  <= a[EW-1] ^ b[BW-1] ^ cmd.sub;
			clr_q  <= cmd.clear;
			prod_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == 3'(NCH)) begin
				acc_q <= neg_q ? base - sp : base + sp;
			end else begin
				prod_q <= (prod_q << CH) + PRW'(part);
				bm_q   <= bm_q << CH;
			end
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule

@@ src/tbe_div.sv @@
module tbe_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [tbe_pkg::BW-1:0]    num,
	input  logic signed [tbe_pkg::ACC_W-1:0] den,
	output logic                             done,
	output logic signed [tbe_pkg::INV_W-1:0] quo
);
	import tbe_pkg::*;

	localparam int NW  = BW + INV_W;
	localparam int CW  = $clog2(NW);

	logic             busy_q, fin_q, done_q, neg_q, ovf_q;
	logic [CW-1:0]    cnt_q;
	logic [NW-1:0]    nm_q;
	logic [ACC_W-1:0] dm_q, rem_q;
	logic [INV_W:0]   q_q;
	logic signed [INV_W-1:0] quo_q;
	logic [BW-1:0]    n_mag;
	logic [ACC_W-1:0] d_mag;
	logic [ACC_W:0]   r2, diff;
	logic             ge, big_pos, big_neg;

	assign n_mag = num[BW-1] ? (~num + 1'b1) : num;
	assign d_mag = den[ACC_W-1] ? (~den + 1'b1) : den;
	assign r2    = {rem_q, nm_q[NW-1]};
	assign diff  = r2 - {1'b0, dm_q};
	assign ge    = r2 >= {1'b0, dm_q};
	assign big_pos = ovf_q | q_q[INV_W] | q_q[INV_W-1];
	assign big_neg = ovf_q | q_q[INV_W] | (q_q[INV_W-1] & (|q_q[INV_W-2:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// restoring division, one quotient bit a cycle; bits past the 49th only flag overflow
	always_ff @(posedge clk) begin
		if (start) begin
			nm_q  <= NW'(n_mag) << INV_W;
			dm_q  <= d_mag;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
			neg_q <= num[BW-1] ^ den[ACC_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? diff[ACC_W-1:0] : r2[ACC_W-1:0];
			q_q   <= {q_q[INV_W-1:0], ge};
			ovf_q <= ovf_q | q_q[INV_W];
			nm_q  <= nm_q << 1;
		end else if (fin_q) begin
			if (neg_q) quo_q <= big_neg ? {1'b1, {(INV_W-1){1'b0}}} : -q_q[INV_W-1:0];
			else       quo_q <= big_pos ? {1'b0, {(INV_W-1){1'b1}}} : q_q[INV_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

@@ src/tet_barycentric_engine.sv @@
// Tetrahedron table with barycentric queries.
// req (sink): op, tet_index, corner_slot, pos_x/y/z. One beat is taken when valid and
//   ready are high; ready is high only while the engine is idle.
// rsp (source): bary_0..bary_3 (Q8.24), inside_res, degenerate. Exactly one beat per
//   request beat, in order, held in an output register until taken.
// Load (op 0): writes one corner, re-reads the four corners, forms the adjugate and
//   determinant on a shared 33x17 multiply-accumulate unit (21 products) and then nine
//   inverse entries on a shared radix-2 divider; a zero determinant skips the divides.
// Query (op 1): reads corner 0 and the inverse, nine products on the same MAC unit;
//   a query on a degenerate tetrahedron skips the reads and products.
// A new request is taken while the previous response still waits; a stalled rsp
//   holds the engine in its final state until the output register frees.
// Reset clears the degenerate marks and the handshake state; the corner and inverse
//   RAMs are not cleared, so every corner must be loaded before a query.
module tet_barycentric_engine #(
	parameter int TET_SLOTS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	tbe_req_if.sink    req,
	tbe_rsp_if.source  rsp
);
	import tbe_pkg::*;

	localparam int SLOT_W = (TET_SLOTS > 1) ? $clog2(TET_SLOTS) : 1;
	localparam int CA_W   = $clog2(TET_SLOTS * CORNER_WORDS);
	localparam int IA_W   = $clog2(TET_SLOTS * INV_WORDS);

	function automatic logic [SLOT_W-1:0] slot_of(input logic [3:0] v);
		logic [SLOT_W-1:0] r;
		r = '0;
		for (int n = 0; n < 16; n++)
			if (v == 4'(n)) r = SLOT_W'(n % TET_SLOTS);
		return r;
	endfunction

	st_t state_q, state_d;

	logic                  in_rdy, accept;
	logic [SLOT_W-1:0]     slot_q;
	logic [1:0]            cs_q;
	logic signed [PW-1:0]  pos_q [AXES];
	logic [TET_SLOTS-1:0]  deg_q;

	logic [3:0]            cnt_q, k_q, cap_k_q;
	logic [1:0]            i_q, j_q, ra_c_q, ra_a_q, cap_c_q, cap_a_q;
	logic                  t_q, issued_q, cap_vld_q, out_vld_q;

	logic signed [PW-1:0]    cor_q [4][AXES];
	logic signed [EW-1:0]    m_q [3][3];
	logic signed [BW-1:0]    adj_q [INV_WORDS];
	logic signed [ACC_W-1:0] det_q;
	logic signed [INV_W-1:0] inv_q [INV_WORDS];
	logic signed [EW-1:0]    d_q [AXES];
	logic signed [RC_W-1:0]  rc_q [3];
	logic signed [PW-1:0]    res_b_q [4];
	logic                    res_in_q;
	logic signed [PW-1:0]    out_b_q [4];
	logic                    out_in_q, out_deg_q;

	mac_cmd_t                mac_cmd;
	logic signed [EW-1:0]    mac_a;
	logic signed [BW-1:0]    mac_b;
	logic signed [ACC_W-1:0] mac_init, mac_acc;
	logic                    mac_done;
	logic                    div_go, div_done;
	logic signed [INV_W-1:0] div_q;

	logic                    cwe, iwe;
	logic [CA_W-1:0]         c_base, cwaddr, craddr;
	logic [IA_W-1:0]         i_base, iwaddr, iraddr;
	logic [PW-1:0]           crd;
	logic [INV_W-1:0]        ird;

	logic [1:0]              ip1, ip2, jp1, jp2;
	logic signed [BS_W-1:0]  bs [4];
	logic signed [PW-1:0]    bq [4];
	logic                    inside_c;

	assign accept = req.valid && in_rdy;
	assign ip1 = inc3(i_q);
	assign ip2 = inc3(ip1);
	assign jp1 = inc3(j_q);
	assign jp2 = inc3(jp1);

	assign c_base = CA_W'(slot_q) * CA_W'(CORNER_WORDS);
	assign cwaddr = c_base + CA_W'(cs_q) * CA_W'(AXES) + CA_W'(cnt_q);
	assign craddr = (state_q == ST_LRD) ? c_base + CA_W'(ra_c_q) * CA_W'(AXES) + CA_W'(ra_a_q)
		: c_base + CA_W'(cnt_q);
	assign i_base = IA_W'(slot_q) * IA_W'(INV_WORDS);
	assign iwaddr = i_base + IA_W'(k_q);
	assign iraddr = i_base + IA_W'(cnt_q);

	tbe_ram #(.WIDTH(PW), .DEPTH(TET_SLOTS * CORNER_WORDS)) u_corner_ram (
		.clk(clk), .we(cwe), .waddr(cwaddr), .wdata(pos_q[cnt_q[1:0]]),
		.raddr(craddr), .rdata(crd)
	);

	tbe_ram #(.WIDTH(INV_W), .DEPTH(TET_SLOTS * INV_WORDS)) u_inv_ram (
		.clk(clk), .we(iwe), .waddr(iwaddr), .wdata(div_q),
		.raddr(iraddr), .rdata(ird)
	);

	tbe_mac u_mac (
		.clk(clk), .arst_n(arst_n), .cmd(mac_cmd), .a(mac_a), .b(mac_b),
		.init(mac_init), .done(mac_done), .acc(mac_acc)
	);

	tbe_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go), .num(adj_q[k_q]), .den(det_q),
		.done(div_done), .quo(div_q)
	);

	// weights: corner 0 is one minus the rest, all saturated before the inside test
	always_comb begin
		bs[0] = BS_W'(ONE_Q24) - BS_W'(rc_q[0]) - BS_W'(rc_q[1]) - BS_W'(rc_q[2]);
		bs[1] = BS_W'(rc_q[0]);
		bs[2] = BS_W'(rc_q[1]);
		bs[3] = BS_W'(rc_q[2]);
		inside_c = 1'b1;
		for (int n = 0; n < 4; n++) begin
			bq[n] = sat32(bs[n]);
			if (bq[n] < 0 || bq[n] > ONE_Q24) inside_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		in_rdy   = 1'b0;
		mac_cmd  = '0;
		mac_a    = '0;
		mac_b    = '0;
		mac_init = '0;
		div_go   = 1'b0;
		cwe      = 1'b0;
		iwe      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_rdy = 1'b1;
				if (req.valid) begin
					if (req.op == OP_LOAD) state_d = ST_WR;
					else if (deg_q[slot_of(req.tet_index)]) state_d = ST_DONE;
					else state_d = ST_QRD;
				end
			end
			ST_WR: begin
				cwe = 1'b1;
				if (cnt_q == 4'd2) state_d = ST_LRD;
			end
			ST_LRD: begin
				if (cap_vld_q && cap_c_q == 2'd3 && cap_a_q == 2'd2) state_d = ST_EDGE;
			end
			ST_EDGE: state_d = ST_ADJ;
			ST_ADJ: begin
				mac_cmd.start = !issued_q;
				mac_cmd.clear = !t_q;
				mac_cmd.sub   = t_q;
				mac_a = t_q ? m_q[jp1][ip2] : m_q[jp1][ip1];
				mac_b = t_q ? BW'(m_q[jp2][ip1]) : BW'(m_q[jp2][ip2]);
				if (mac_done && t_q && i_q == 2'd2 && j_q == 2'd2) state_d = ST_DET;
			end
			ST_DET: begin
				mac_cmd.start = !issued_q;
				mac_cmd.clear = (i_q == 2'd0);
				mac_a = m_q[0][i_q];
				mac_b = adj_q[idx9(i_q, 2'd0)];
				if (mac_done && i_q == 2'd2) state_d = ST_CHK;
			end
			ST_CHK: begin
				if (det_q == '0) state_d = ST_DONE;
				else state_d = ST_INV;
			end
			ST_INV: begin
				div_go = !issued_q;
				iwe    = div_done;
				if (div_done && k_q == 4'(INV_WORDS - 1)) state_d = ST_DONE;
			end
			ST_QRD: begin
				if (cap_vld_q && cap_k_q == 4'(INV_WORDS - 1)) state_d = ST_QDIFF;
			end
			ST_QDIFF: state_d = ST_QMAC;
			ST_QMAC: begin
				mac_cmd.start = !issued_q;
				mac_cmd.clear = (j_q == 2'd0);
				mac_init = RND_HALF;
				mac_a = d_q[j_q];
				mac_b = BW'(inv_q[k_q]);
				if (mac_done && i_q == 2'd2 && j_q == 2'd2) state_d = ST_QFIN;
			end
			ST_QFIN: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_vld_q || rsp.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			k_q       <= '0;
			i_q       <= '0;
			j_q       <= '0;
			t_q       <= 1'b0;
			ra_c_q    <= '0;
			ra_a_q    <= '0;
			issued_q  <= 1'b0;
			cap_vld_q <= 1'b0;
			cap_c_q   <= '0;
			cap_a_q   <= '0;
			cap_k_q   <= '0;
			out_vld_q <= 1'b0;
			deg_q     <= '0;
		end else begin
			if (mac_cmd.start || div_go) issued_q <= 1'b1;
			else if (mac_done || div_done) issued_q <= 1'b0;

			cap_vld_q <= (state_q == ST_LRD) || (state_q == ST_QRD);
			cap_c_q   <= ra_c_q;
			cap_a_q   <= ra_a_q;
			cap_k_q   <= cnt_q;

			case (state_q)
				ST_IDLE: begin
					cnt_q  <= '0;
					ra_c_q <= '0;
					ra_a_q <= '0;
					i_q    <= '0;
					j_q    <= '0;
					k_q    <= '0;
					t_q    <= 1'b0;
				end
				ST_WR: cnt_q <= cnt_q + 4'd1;
				ST_LRD: begin
					if (ra_a_q == 2'd2) begin
						ra_a_q <= '0;
						ra_c_q <= ra_c_q + 2'd1;
					end else begin
						ra_a_q <= ra_a_q + 2'd1;
					end
				end
				ST_QRD: cnt_q <= cnt_q + 4'd1;
				ST_ADJ, ST_INV, ST_QMAC: begin
					if ((state_q == ST_ADJ && mac_done && t_q) ||
						(state_q == ST_INV && div_done) ||
						(state_q == ST_QMAC && mac_done)) begin
						j_q <= inc3(j_q);
						if (j_q == 2'd2) i_q <= inc3(i_q);
						k_q <= (k_q == 4'(INV_WORDS - 1)) ? 4'd0 : k_q + 4'd1;
					end
					if (state_q == ST_ADJ && mac_done) t_q <= !t_q;
				end
				ST_DET: begin
					if (mac_done) i_q <= inc3(i_q);
				end
				ST_CHK: deg_q[slot_q] <= (det_q == '0);
				default: ;
			endcase

			if (state_q == ST_DONE && state_d == ST_IDLE) out_vld_q <= 1'b1;
			else if (rsp.ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q   <= slot_of(req.tet_index);
			cs_q     <= req.corner_slot;
			pos_q[0] <= req.pos_x;
			pos_q[1] <= req.pos_y;
			pos_q[2] <= req.pos_z;
			for (int n = 0; n < 4; n++) res_b_q[n] <= '0;
			res_in_q <= 1'b0;
		end
		if (cap_vld_q && state_q == ST_LRD) cor_q[cap_c_q][cap_a_q] <= crd;
		if (cap_vld_q && state_q == ST_QRD) begin
			if (cap_k_q < 4'(AXES)) cor_q[0][cap_k_q[1:0]] <= crd;
			inv_q[cap_k_q] <= ird;
		end
		case (state_q)
			ST_EDGE: begin
				for (int r = 0; r < 3; r++)
					for (int c = 0; c < 3; c++)
						m_q[r][c] <= EW'(cor_q[c+1][r]) - EW'(cor_q[0][r]);
			end
			ST_ADJ: if (mac_done && t_q) adj_q[k_q] <= mac_acc[BW-1:0];
			ST_DET: if (mac_done && i_q == 2'd2) det_q <= mac_acc;
			ST_QDIFF: begin
				for (int n = 0; n < AXES; n++) d_q[n] <= EW'(pos_q[n]) - EW'(cor_q[0][n]);
			end
			ST_QMAC: if (mac_done && j_q == 2'd2) rc_q[i_q] <= mac_acc[ACC_W-1:FRAC_SH];
			ST_QFIN: begin
				for (int n = 0; n < 4; n++) res_b_q[n] <= bq[n];
				res_in_q <= inside_c;
			end
			ST_DONE: begin
				if (state_d == ST_IDLE) begin
					for (int n = 0; n < 4; n++) out_b_q[n] <= res_b_q[n];
					out_in_q  <= res_in_q;
					out_deg_q <= deg_q[slot_q];
				end
			end
			default: ;
		endcase
	end

	assign req.ready      = in_rdy;
	assign rsp.valid      = out_vld_q;
	assign rsp.bary_0     = out_b_q[0];
	assign rsp.bary_1     = out_b_q[1];
	assign rsp.bary_2     = out_b_q[2];
	assign rsp.bary_3     = out_b_q[3];
	assign rsp.inside_res = out_in_q;
	assign rsp.degenerate = out_deg_q;

endmodule
